// File: sv/rational_arithmetic_unit_assert.svh
// assertion macros shared by the rational arithmetic unit
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define RAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/rau_pkg.sv
package rau_pkg;

    localparam int DEF_WIDTH = 32;

    // operation codes of an input request
    localparam logic [2:0] KIND_ADD      = 3'd0;
    localparam logic [2:0] KIND_SUB      = 3'd1;
    localparam logic [2:0] KIND_MUL      = 3'd2;
    localparam logic [2:0] KIND_LESS     = 3'd3;
    localparam logic [2:0] KIND_GREATER  = 3'd4;
    localparam logic [2:0] KIND_EQUAL    = 3'd5;
    localparam logic [2:0] KIND_SIMPLIFY = 3'd6;
    localparam logic [2:0] KIND_SIMPLEST = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    // shared arithmetic engine operations
    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_GCD
    } eng_op_t;

    typedef struct packed {
        logic    start;
        eng_op_t op;
    } eng_req_t;

    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL,
        E_DIV,
        E_GSH,
        E_GLP,
        E_GUN
    } eng_state_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_AS_G,
        S_AS_FA,
        S_AS_FB,
        S_AS_P1,
        S_AS_P2,
        S_AS_D,
        S_AS_SUM,
        S_M_N,
        S_M_D,
        S_C_X,
        S_C_Y,
        S_IS_G,
        S_RED,
        S_RED_G,
        S_RED_N,
        S_RED_D,
        S_FIN,
        S_OUT
    } rau_state_t;

endpackage

// File: sv/rau_engine.sv
module rau_engine #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH,
    localparam int L = 2 * WIDTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rau_pkg::eng_req_t  req,
    input  logic [L-1:0]       x,
    input  logic [L-1:0]       y,
    output logic               done,
    output logic [L-1:0]       res
);
    import rau_pkg::*;

    localparam int CW = $clog2(L);
    localparam int KW = $clog2(L + 1);

    eng_state_t     state_reg, state_next;
    logic [L-1:0]   u_reg, u_next;
    logic [L-1:0]   v_reg, v_next;
    logic [L-1:0]   acc_reg, acc_next;
    logic [L-1:0]   rem_reg, rem_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [KW-1:0]  k_reg, k_next;
    logic           done_reg, done_next;
    logic [L-1:0]   res_reg, res_next;
    logic [L:0]     rsh;
    logic           qbit;

    // state and control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= E_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        u_reg   <= u_next;
        v_reg   <= v_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
        k_reg   <= k_next;
        res_reg <= res_next;
    end

    // one division step: shift next dividend bit into the remainder
    assign rsh  = {rem_reg, u_reg[L-1]};
    assign qbit = (rsh >= {1'b0, v_reg});

    // sequencer of multiply, divide and binary gcd
    always_comb begin
        state_next = state_reg;
        u_next     = u_reg;
        v_next     = v_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        unique case (state_reg)
            E_IDLE: begin
                if (req.start) begin
                    u_next   = x;
                    v_next   = y;
                    acc_next = '0;
                    rem_next = '0;
                    cnt_next = CW'(L - 1);
                    k_next   = '0;
                    unique case (req.op)
                        OP_MUL:  state_next = E_MUL;
                        OP_DIV:  state_next = E_DIV;
                        OP_GCD:  state_next = E_GSH;
                        default: state_next = E_IDLE;
                    endcase
                end
            end
            E_MUL: begin
                if (v_reg == '0) begin
                    res_next   = acc_reg;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end else begin
                    if (v_reg[0]) begin
                        acc_next = acc_reg + u_reg;
                    end
                    u_next = {u_reg[L-2:0], 1'b0};
                    v_next = {1'b0, v_reg[L-1:1]};
                end
            end
            E_DIV: begin
                rem_next = qbit ? L'(rsh - {1'b0, v_reg}) : rsh[L-1:0];
                acc_next = {acc_reg[L-2:0], qbit};
                u_next   = {u_reg[L-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    res_next   = {acc_reg[L-2:0], qbit};
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end
            end
            E_GSH: begin
                // strip common factors of two
                if (u_reg == '0) begin
                    state_next = E_GUN;
                end else if (v_reg == '0) begin
                    v_next     = u_reg;
                    state_next = E_GUN;
                end else if (u_reg[0] || v_reg[0]) begin
                    state_next = E_GLP;
                end else begin
                    u_next = {1'b0, u_reg[L-1:1]};
                    v_next = {1'b0, v_reg[L-1:1]};
                    k_next = k_reg + 1'b1;
                end
            end
            E_GLP: begin
                if (u_reg == '0) begin
                    state_next = E_GUN;
                end else if (!u_reg[0]) begin
                    u_next = {1'b0, u_reg[L-1:1]};
                end else if (!v_reg[0]) begin
                    v_next = {1'b0, v_reg[L-1:1]};
                end else if (u_reg >= v_reg) begin
                    u_next = u_reg - v_reg;
                end else begin
                    v_next = v_reg - u_reg;
                end
            end
            E_GUN: begin
                // restore the common power of two
                if (k_reg == '0) begin
                    res_next   = v_reg;
                    done_next  = 1'b1;
                    state_next = E_IDLE;
                end else begin
                    v_next = {v_reg[L-2:0], 1'b0};
                    k_next = k_reg - 1'b1;
                end
            end
            default: state_next = E_IDLE;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

// File: sv/rational_arithmetic_unit.sv
// Rational arithmetic unit: one request carries an operation code in s_tuser and two
// signed fractions in s_tdata; one result comes back on m_tdata. The block handles one
// request at a time and is not ready until its result has been taken. All work runs
// through one shared engine that multiplies by shift-add (one multiplier bit a cycle),
// divides by restoring steps and takes a binary gcd (one shift or subtract a cycle).
// Add and sub take a gcd of denominators, two divisions and three products before the
// reduction. Results that do not fit WIDTH signed bits report overflow with zero fields.
module rational_arithmetic_unit #(
    parameter int WIDTH = rau_pkg::DEF_WIDTH,
    localparam int IN_W  = ((4 * WIDTH + 7) / 8) * 8,
    localparam int OUT_W = ((2 * WIDTH + 3 + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // a_num, a_den, b_num, b_den from the lowest bit up
    input  logic [IN_W-1:0]  s_tdata,
    // kind
    input  logic [2:0]       s_tuser,
    output logic             m_tvalid,
    input  logic             m_tready,
    // res_num, res_den, flag, status from the lowest bit up
    output logic [OUT_W-1:0] m_tdata
);
    import rau_pkg::*;

    `include "rational_arithmetic_unit_assert.svh"

    localparam int L = 2 * WIDTH;
    localparam logic [WIDTH-1:0] SBIT = {1'b1, {(WIDTH-1){1'b0}}};

    rau_state_t       state_reg, state_next;
    logic [2:0]       kind_reg, kind_next;
    logic [WIDTH-1:0] an_m_reg, an_m_next, ad_m_reg, ad_m_next;
    logic [WIDTH-1:0] bn_m_reg, bn_m_next, bd_m_reg, bd_m_next;
    logic             an_n_reg, an_n_next, ad_n_reg, ad_n_next;
    logic             bn_n_reg, bn_n_next, bd_n_reg, bd_n_next;
    logic [WIDTH-1:0] fa_reg, fa_next, fb_reg, fb_next;
    logic [L-1:0]     p1_reg, p1_next, p2_reg, p2_next, g_reg, g_next;
    logic [L-1:0]     num_m_reg, num_m_next, den_m_reg, den_m_next;
    logic             num_n_reg, num_n_next, den_n_reg, den_n_next;
    logic [WIDTH-1:0] res_num_reg, res_num_next, res_den_reg, res_den_next;
    logic             flag_reg, flag_next;
    logic [1:0]       status_reg, status_next;

    eng_req_t         eng_req;
    logic [L-1:0]     eng_x, eng_y, eng_res;
    logic             eng_done;

    logic [WIDTH-1:0] in_an, in_ad, in_bn, in_bd;
    logic             sa_n, sb_n, y_n, num_fit, den_fit;
    logic [L-1:0]     sum_m;
    logic             sum_n;

    // magnitude of a two's complement field
    function automatic logic [WIDTH-1:0] mag(input logic [WIDTH-1:0] v);
        mag = v[WIDTH-1] ? (~v + 1'b1) : v;
    endfunction

    // signed magnitude fits the result field
    function automatic logic fits(input logic neg, input logic [L-1:0] m);
        fits = (m[L-1:WIDTH] == '0) && (m[WIDTH-1:0] <= (neg ? SBIT : SBIT - 1'b1));
    endfunction

    function automatic logic [WIDTH-1:0] to_field(input logic neg, input logic [L-1:0] m);
        to_field = neg ? (~m[WIDTH-1:0] + 1'b1) : m[WIDTH-1:0];
    endfunction

    assign in_an = s_tdata[WIDTH-1:0];
    assign in_ad = s_tdata[2*WIDTH-1:WIDTH];
    assign in_bn = s_tdata[3*WIDTH-1:2*WIDTH];
    assign in_bd = s_tdata[4*WIDTH-1:3*WIDTH];

    rau_engine #(.WIDTH(WIDTH)) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (eng_req),
        .x       (eng_x),
        .y       (eng_y),
        .done    (eng_done),
        .res     (eng_res)
    );

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        an_m_reg    <= an_m_next;
        ad_m_reg    <= ad_m_next;
        bn_m_reg    <= bn_m_next;
        bd_m_reg    <= bd_m_next;
        an_n_reg    <= an_n_next;
        ad_n_reg    <= ad_n_next;
        bn_n_reg    <= bn_n_next;
        bd_n_reg    <= bd_n_next;
        fa_reg      <= fa_next;
        fb_reg      <= fb_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        g_reg       <= g_next;
        num_m_reg   <= num_m_next;
        den_m_reg   <= den_m_next;
        num_n_reg   <= num_n_next;
        den_n_reg   <= den_n_next;
        res_num_reg <= res_num_next;
        res_den_reg <= res_den_next;
        flag_reg    <= flag_next;
        status_reg  <= status_next;
    end

    // signed sum of the two scaled numerators
    assign sa_n = (ad_n_reg ^ an_n_reg) && (an_m_reg != '0);
    assign sb_n = (bd_n_reg ^ bn_n_reg) && (bn_m_reg != '0);
    always_comb begin
        if (sa_n == sb_n) begin
            sum_m = p1_reg + p2_reg;
            sum_n = sa_n;
        end else if (p1_reg >= p2_reg) begin
            sum_m = p1_reg - p2_reg;
            sum_n = sa_n;
        end else begin
            sum_m = p2_reg - p1_reg;
            sum_n = sb_n;
        end
    end

    assign y_n     = (bn_n_reg ^ ad_n_reg) && (eng_res != '0);
    assign num_fit = fits(num_n_reg, num_m_reg);
    assign den_fit = fits(den_n_reg, den_m_reg);

    // request sequencer
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        an_m_next    = an_m_reg;
        ad_m_next    = ad_m_reg;
        bn_m_next    = bn_m_reg;
        bd_m_next    = bd_m_reg;
        an_n_next    = an_n_reg;
        ad_n_next    = ad_n_reg;
        bn_n_next    = bn_n_reg;
        bd_n_next    = bd_n_reg;
        fa_next      = fa_reg;
        fb_next      = fb_reg;
        p1_next      = p1_reg;
        p2_next      = p2_reg;
        g_next       = g_reg;
        num_m_next   = num_m_reg;
        den_m_next   = den_m_reg;
        num_n_next   = num_n_reg;
        den_n_next   = den_n_reg;
        res_num_next = res_num_reg;
        res_den_next = res_den_reg;
        flag_next    = flag_reg;
        status_next  = status_reg;
        eng_req      = '{start: 1'b0, op: OP_MUL};
        eng_x        = '0;
        eng_y        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    kind_next    = s_tuser;
                    an_m_next    = mag(in_an);
                    ad_m_next    = mag(in_ad);
                    bn_m_next    = mag(in_bn);
                    bd_m_next    = mag(in_bd);
                    an_n_next    = in_an[WIDTH-1];
                    ad_n_next    = in_ad[WIDTH-1];
                    bn_n_next    = in_bn[WIDTH-1];
                    bd_n_next    = in_bd[WIDTH-1];
                    res_num_next = '0;
                    res_den_next = '0;
                    flag_next    = 1'b0;
                    status_next  = ST_OK;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (kind_reg)
                    KIND_ADD, KIND_SUB: begin
                        if (ad_m_reg == '0 || bd_m_reg == '0) begin
                            status_next = ST_ZERO;
                            state_next  = S_OUT;
                        end else begin
                            if (kind_reg == KIND_SUB) begin
                                bn_n_next = !bn_n_reg && (bn_m_reg != '0);
                            end
                            eng_req    = '{start: 1'b1, op: OP_GCD};
                            eng_x      = L'(ad_m_reg);
                            eng_y      = L'(bd_m_reg);
                            state_next = S_AS_G;
                        end
                    end
                    KIND_MUL: begin
                        eng_req    = '{start: 1'b1, op: OP_MUL};
                        eng_x      = L'(an_m_reg);
                        eng_y      = L'(bn_m_reg);
                        state_next = S_M_N;
                    end
                    KIND_LESS, KIND_GREATER: begin
                        eng_req    = '{start: 1'b1, op: OP_MUL};
                        eng_x      = L'(an_m_reg);
                        eng_y      = L'(bd_m_reg);
                        state_next = S_C_X;
                    end
                    KIND_EQUAL: begin
                        flag_next  = (an_n_reg == bn_n_reg) && (an_m_reg == bn_m_reg) &&
                                     (ad_n_reg == bd_n_reg) && (ad_m_reg == bd_m_reg);
                        state_next = S_OUT;
                    end
                    KIND_SIMPLIFY: begin
                        num_m_next = L'(an_m_reg);
                        num_n_next = an_n_reg;
                        den_m_next = L'(ad_m_reg);
                        den_n_next = ad_n_reg;
                        state_next = S_RED;
                    end
                    default: begin
                        eng_req    = '{start: 1'b1, op: OP_GCD};
                        eng_x      = L'(an_m_reg);
                        eng_y      = L'(ad_m_reg);
                        state_next = S_IS_G;
                    end
                endcase
            end
            // add and sub: common denominator
            S_AS_G: begin
                if (eng_done) begin
                    g_next     = eng_res;
                    eng_req    = '{start: 1'b1, op: OP_DIV};
                    eng_x      = L'(bd_m_reg);
                    eng_y      = eng_res;
                    state_next = S_AS_FA;
                end
            end
            S_AS_FA: begin
                if (eng_done) begin
                    fa_next    = eng_res[WIDTH-1:0];
                    eng_req    = '{start: 1'b1, op: OP_DIV};
                    eng_x      = L'(ad_m_reg);
                    eng_y      = g_reg;
                    state_next = S_AS_FB;
                end
            end
            S_AS_FB: begin
                if (eng_done) begin
                    fb_next    = eng_res[WIDTH-1:0];
                    eng_req    = '{start: 1'b1, op: OP_MUL};
                    eng_x      = L'(an_m_reg);
                    eng_y      = L'(fa_reg);
                    state_next = S_AS_P1;
                end
            end
            S_AS_P1: begin
                if (eng_done) begin
                    p1_next    = eng_res;
                    eng_req    = '{start: 1'b1, op: OP_MUL};
                    eng_x      = L'(bn_m_reg);
                    eng_y      = L'(fb_reg);
                    state_next = S_AS_P2;
                end
            end
            S_AS_P2: begin
                if (eng_done) begin
                    p2_next    = eng_res;
                    eng_req    = '{start: 1'b1, op: OP_MUL};
                    eng_x      = L'(ad_m_reg);
                    eng_y      = L'(fa_reg);
                    state_next = S_AS_D;
                end
            end
            S_AS_D: begin
                if (eng_done) begin
                    den_m_next = eng_res;
                    den_n_next = 1'b0;
                    state_next = S_AS_SUM;
                end
            end
            S_AS_SUM: begin
                num_m_next = sum_m;
                num_n_next = sum_n && (sum_m != '0);
                state_next = S_RED;
            end
            // mul: numerator and denominator products
            S_M_N: begin
                if (eng_done) begin
                    num_m_next = eng_res;
                    num_n_next = (an_n_reg ^ bn_n_reg) && (eng_res != '0);
                    eng_req    = '{start: 1'b1, op: OP_MUL};
                    eng_x      = L'(ad_m_reg);
                    eng_y      = L'(bd_m_reg);
                    state_next = S_M_D;
                end
            end
            S_M_D: begin
                if (eng_done) begin
                    den_m_next = eng_res;
                    den_n_next = (ad_n_reg ^ bd_n_reg) && (eng_res != '0);
                    state_next = S_RED;
                end
            end
            // compare by cross products
            S_C_X: begin
                if (eng_done) begin
                    p1_next    = eng_res;
                    num_n_next = (an_n_reg ^ bd_n_reg) && (eng_res != '0);
                    eng_req    = '{start: 1'b1, op: OP_MUL};
                    eng_x      = L'(bn_m_reg);
                    eng_y      = L'(ad_m_reg);
                    state_next = S_C_Y;
                end
            end
            S_C_Y: begin
                if (eng_done) begin
                    if (kind_reg == KIND_LESS) begin
                        if (num_n_reg != y_n) flag_next = num_n_reg;
                        else if (num_n_reg) flag_next = eng_res < p1_reg;
                        else flag_next = p1_reg < eng_res;
                    end else begin
                        if (num_n_reg != y_n) flag_next = y_n;
                        else if (num_n_reg) flag_next = p1_reg < eng_res;
                        else flag_next = p1_reg > eng_res;
                    end
                    state_next = S_OUT;
                end
            end
            S_IS_G: begin
                if (eng_done) begin
                    if (eng_res == '0) begin
                        status_next = ST_ZERO;
                    end else begin
                        flag_next = (eng_res == L'(1));
                    end
                    state_next = S_OUT;
                end
            end
            // reduction by gcd of magnitudes
            S_RED: begin
                eng_req    = '{start: 1'b1, op: OP_GCD};
                eng_x      = num_m_reg;
                eng_y      = den_m_reg;
                state_next = S_RED_G;
            end
            S_RED_G: begin
                if (eng_done) begin
                    if (eng_res == '0) begin
                        status_next = ST_ZERO;
                        state_next  = S_OUT;
                    end else begin
                        g_next     = eng_res;
                        eng_req    = '{start: 1'b1, op: OP_DIV};
                        eng_x      = num_m_reg;
                        eng_y      = eng_res;
                        state_next = S_RED_N;
                    end
                end
            end
            S_RED_N: begin
                if (eng_done) begin
                    num_m_next = eng_res;
                    eng_req    = '{start: 1'b1, op: OP_DIV};
                    eng_x      = den_m_reg;
                    eng_y      = g_reg;
                    state_next = S_RED_D;
                end
            end
            S_RED_D: begin
                if (eng_done) begin
                    den_m_next = eng_res;
                    state_next = S_FIN;
                end
            end
            S_FIN: begin
                if (num_fit && den_fit) begin
                    res_num_next = to_field(num_n_reg, num_m_reg);
                    res_den_next = to_field(den_n_reg, den_m_reg);
                end else begin
                    status_next = ST_OVF;
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = (state_reg == S_OUT);
    assign m_tdata  = OUT_W'({status_reg, flag_reg, res_den_reg, res_num_reg});

    `RAU_ASSERT_NOW(a_one_side, s_tready, !m_tvalid, "ready while a result is pending")
    `RAU_ASSERT_NEXT(a_back_idle, m_tvalid && m_tready, s_tready, "not ready after result")
    `RAU_ASSERT_NOW(a_bad_zero, m_tvalid && (status_reg != ST_OK),
        (res_num_reg == '0) && (res_den_reg == '0), "failed result carries data")
    `RAU_ASSERT_NOW(a_done_wait, eng_done, (state_reg != S_IDLE) && (state_reg != S_OUT),
        "engine finished with no request in work")

endmodule

// File: verif/rational_arithmetic_unit_tb.sv
module rational_arithmetic_unit_tb;
    import rau_pkg::*;

    localparam int W = 32;
    localparam int IN_W = 128;
    localparam int OUT_W = 72;
    localparam int N_RANDOM = 950;
    localparam longint CYCLE_LIMIT = 64'd6000000;

    typedef struct packed {
        logic [1:0]   status;
        logic         flag;
        logic [W-1:0] den;
        logic [W-1:0] num;
    } frac_result_t;

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [2:0]       s_tuser;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    rational_arithmetic_unit #(.WIDTH(W)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // exact signed arithmetic on wide vectors
    function automatic logic [127:0] wide_gcd(logic [127:0] a, logic [127:0] b);
        logic [127:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic fits_field(logic signed [255:0] v);
        return v >= -(256'sd1 <<< (W - 1)) && v <= ((256'sd1 <<< (W - 1)) - 1);
    endfunction

    function automatic frac_result_t pack_result(logic signed [255:0] n,
            logic signed [255:0] d, logic flag, logic [1:0] st);
        frac_result_t r;
        r = '0;
        r.flag = flag;
        if (st == ST_OK && (!fits_field(n) || !fits_field(d))) st = ST_OVF;
        if (st == ST_OK) begin
            r.num = n[W-1:0];
            r.den = d[W-1:0];
        end
        r.status = st;
        return r;
    endfunction

    function automatic logic [127:0] mag(logic signed [255:0] v);
        return v < 0 ? 128'(-v) : 128'(v);
    endfunction

    // divide by the gcd of magnitudes, signs kept
    function automatic frac_result_t reduce_frac(logic signed [255:0] n,
            logic signed [255:0] d);
        logic [127:0] g;
        logic signed [255:0] gs;
        g = wide_gcd(mag(n), mag(d));
        if (g == 0) return pack_result(0, 0, 1'b0, ST_ZERO);
        gs = $signed({128'd0, g});
        return pack_result(n / gs, d / gs, 1'b0, ST_OK);
    endfunction

    function automatic frac_result_t predict_fraction(logic [2:0] kind,
            logic [W-1:0] an, logic [W-1:0] ad, logic [W-1:0] bn, logic [W-1:0] bd);
        logic signed [255:0] xn, xd, yn, yd, fa, fb, ta, tb, lcm;
        logic [127:0] g;
        xn = $signed(an); xd = $signed(ad); yn = $signed(bn); yd = $signed(bd);
        case (kind)
            KIND_ADD, KIND_SUB: begin
                if (xd == 0 || yd == 0) return pack_result(0, 0, 1'b0, ST_ZERO);
                if (kind == KIND_SUB) yn = -yn;
                g = wide_gcd(mag(xd), mag(yd));
                fa = $signed({128'd0, mag(yd) / g});
                fb = $signed({128'd0, mag(xd) / g});
                ta = xd < 0 ? -xn : xn;
                tb = yd < 0 ? -yn : yn;
                lcm = $signed({128'd0, mag(xd)}) * fa;
                return reduce_frac(ta * fa + tb * fb, lcm);
            end
            KIND_MUL: return reduce_frac(xn * yn, xd * yd);
            KIND_LESS: return pack_result(0, 0, xn * yd < yn * xd, ST_OK);
            KIND_GREATER: return pack_result(0, 0, xn * yd > yn * xd, ST_OK);
            KIND_EQUAL: return pack_result(0, 0, an == bn && ad == bd, ST_OK);
            KIND_SIMPLIFY: return reduce_frac(xn, xd);
            default: begin
                g = wide_gcd(mag(xn), mag(xd));
                if (g == 0) return pack_result(0, 0, 1'b0, ST_ZERO);
                return pack_result(0, 0, g == 1, ST_OK);
            end
        endcase
    endfunction

    // in-order store of predicted results
    class frac_scoreboard;
        frac_result_t pending[$];
        int errors;
        int checked;

        function void note_request(logic [2:0] kind, logic [IN_W-1:0] data);
            pending.push_back(predict_fraction(kind, data[31:0], data[63:32],
                data[95:64], data[127:96]));
        endfunction

        function void check_result(logic [OUT_W-1:0] data);
            frac_result_t got, want;
            got = data[2*W+2:0];
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.num !== want.num || got.den !== want.den || got.flag !== want.flag ||
                    got.status !== want.status) begin
                $display({"%0t: mismatch expected num %h den %h flag %b st %0d,",
                    " actual num %h den %h flag %b st %0d"},
                    $time, want.num, want.den, want.flag, want.status,
                    got.num, got.den, got.flag, got.status);
                errors++;
            end
        endfunction
    endclass

    frac_scoreboard board;
    longint cycles;
    int burst_left;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // output side: stall pattern and checking
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn) begin
            if (m_tvalid && m_tready) board.check_result(m_tdata);
            m_tready <= ($urandom_range(0, 9) < 6) || cycles[9];
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 0;
            4: return 1;
            5, 6: return $urandom_range(0, 40) - 20;
            7: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // one request, with a gap before each new burst; valid stays up inside a burst
    task automatic send_request(logic [2:0] kind, logic [W-1:0] an, logic [W-1:0] ad,
            logic [W-1:0] bn, logic [W-1:0] bd);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {bd, bn, ad, an};
        do @(posedge aclk); while (!s_tready);
        board.note_request(kind, {bd, bn, ad, an});
    endtask

    // drop valid and hold off until every result is back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    initial begin
        logic [2:0] k;
        board = new();
        cycles = 0;
        burst_left = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ADD;
        m_tready = 1'b0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed corners
        send_request(KIND_ADD, 1, 2, 1, 3);
        send_request(KIND_ADD, 1, 0, 1, 3);
        send_request(KIND_ADD, 32'h7fff_ffff, 1, 32'h7fff_ffff, 1);
        send_request(KIND_ADD, 3, -4, -5, 6);
        send_request(KIND_SUB, 1, 2, 1, 2);
        send_request(KIND_SUB, 32'h8000_0000, 1, 1, 1);
        send_request(KIND_SUB, 0, 7, 0, -7);
        send_request(KIND_MUL, 0, 0, 5, 0);
        send_request(KIND_MUL, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 1);
        send_request(KIND_MUL, 32'h8000_0000, 1, -1, 1);
        send_request(KIND_MUL, 6, -4, -2, 9);
        send_request(KIND_LESS, 1, 3, 1, 2);
        send_request(KIND_LESS, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_request(KIND_GREATER, 1, -3, 1, 2);
        send_request(KIND_GREATER, 2, 4, 1, 2);
        send_request(KIND_EQUAL, 5, 7, 5, 7);
        send_request(KIND_EQUAL, 5, 7, 10, 14);
        send_request(KIND_SIMPLIFY, 0, 0, 0, 0);
        send_request(KIND_SIMPLIFY, 32'h8000_0000, 32'h8000_0000, 0, 0);
        send_request(KIND_SIMPLIFY, 32'h8000_0000, 1, 0, 0);
        send_request(KIND_SIMPLIFY, -12, 18, 0, 0);
        send_request(KIND_SIMPLEST, 0, 0, 0, 0);
        send_request(KIND_SIMPLEST, 3, 5, 0, 0);
        send_request(KIND_SIMPLEST, 4, -6, 0, 0);

        // sender holds off until everything is back
        wait_drained();

        // random requests
        for (int i = 0; i < N_RANDOM; i++) begin
            k = $urandom_range(0, 7);
            if (k == KIND_EQUAL && $urandom_range(0, 1)) begin
                logic [W-1:0] n, d;
                n = pick_value();
                d = pick_value();
                send_request(k, n, d, n, d);
            end else begin
                send_request(k, pick_value(), pick_value(), pick_value(), pick_value());
            end
            if (i == N_RANDOM / 2) wait_drained();
        end

        wait_drained();
        repeat (1200) @(posedge aclk);
        $display("covered %0d checked results over all eight operations,", board.checked);
        $display("with zero divisors, overflow and sign corners under random stalls");
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
